// File: src/pru_pkg.sv
`default_nettype none
package pru_pkg;

	localparam int MAX_ROW_BYTES = 4096;
	localparam int COL_W = $clog2(MAX_ROW_BYTES);
	localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);
	localparam int ROW_BYTES_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PNG_MODE = 1'd1;

	localparam logic [2:0] FILT_NONE = 3'd0;
	localparam logic [2:0] FILT_SUB = 3'd1;
	localparam logic [2:0] FILT_UP = 3'd2;
	localparam logic [2:0] FILT_AVG = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic new_image;
		logic end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic row_end;
		logic bad_filter;
		logic last_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [COL_W-1:0] col;
		logic [2:0] filt;
		logic first_row;
		logic bad;
		logic ends;
		logic last;
		logic pass;
	} cmd_t;

endpackage
`default_nettype wire

// File: src/pru_ram.sv
`default_nettype none
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/pru_front.sv
`default_nettype none
module pru_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire pru_pkg::in_item_t item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic q_full,
	output logic q_push,
	output pru_pkg::cmd_t q_cmd
);
	import pru_pkg::*;

	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic png_mode_q;
	logic [CNT_W-1:0] col_cnt_q;
	logic first_row_q;
	logic [2:0] filt_q;
	logic bad_q;

	logic accept;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] cnt_e;
	logic first_e;
	logic [CNT_W-1:0] cnt_d;
	logic first_d;
	logic [2:0] filt_d;
	logic bad_d;
	logic [CNT_W-1:0] col_full;
	logic ends;

	assign cfg_ready = 1'b1;
	assign accept = push && !q_full;

	always_comb begin
		if (row_bytes_q == '0) begin
			len = CNT_W'(1);
		end else if (row_bytes_q > ROW_BYTES_W'(MAX_ROW_BYTES)) begin
			len = CNT_W'(MAX_ROW_BYTES);
		end else begin
			len = CNT_W'(row_bytes_q);
		end
	end

	always_comb begin
		cnt_e = item.new_image ? '0 : col_cnt_q;
		first_e = item.new_image ? 1'b1 : first_row_q;
		col_full = cnt_e - CNT_W'(1);
		ends = (cnt_e >= len);
		cnt_d = cnt_e;
		first_d = first_e;
		filt_d = filt_q;
		bad_d = bad_q;
		q_push = 1'b0;
		q_cmd.data_byte = item.in_byte;
		q_cmd.col = col_full[COL_W-1:0];
		q_cmd.filt = filt_q;
		q_cmd.first_row = first_e;
		q_cmd.bad = bad_q;
		q_cmd.ends = ends;
		q_cmd.last = item.end_of_data;
		q_cmd.pass = 1'b0;
		if (!png_mode_q) begin
			q_push = accept;
			q_cmd.pass = 1'b1;
			q_cmd.ends = 1'b0;
			q_cmd.bad = 1'b0;
		end else if (cnt_e == '0) begin
			if (item.in_byte <= 8'(FILT_PAETH)) begin
				filt_d = item.in_byte[2:0];
				bad_d = 1'b0;
			end else begin
				filt_d = FILT_NONE;
				bad_d = 1'b1;
			end
			cnt_d = CNT_W'(1);
		end else begin
			q_push = accept;
			if (ends) begin
				cnt_d = '0;
				first_d = 1'b0;
			end else begin
				cnt_d = cnt_e + CNT_W'(1);
			end
		end
		if (item.end_of_data) begin
			cnt_d = '0;
			first_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_W'(1);
			png_mode_q <= 1'b0;
			col_cnt_q <= '0;
			first_row_q <= 1'b1;
			filt_q <= FILT_NONE;
			bad_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ROW_BYTES: row_bytes_q <= cfg_data[ROW_BYTES_W-1:0];
					REG_PNG_MODE: png_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				col_cnt_q <= cnt_d;
				first_row_q <= first_d;
				filt_q <= filt_d;
				bad_q <= bad_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/pru_queue.sv
`default_nettype none
module pru_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire pru_pkg::cmd_t wr_cmd,
	output logic full,
	input wire logic rd,
	output pru_pkg::cmd_t rd_cmd,
	output logic empty
);
	import pru_pkg::*;

	cmd_t slot_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= !wptr_q;
			end
			if (rd) begin
				rptr_q <= !rptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/pru_back.sv
`default_nettype none
module pru_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire pru_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic empty,
	input wire logic pop,
	output pru_pkg::out_item_t result
);
	import pru_pkg::*;

	cmd_t s1_cmd_s1;
	logic s1_valid_s1;
	logic fwd_s1;
	logic [7:0] left_q;
	logic [7:0] upleft_q;
	logic [7:0] wval_q;
	logic [7:0] rd_data;

	out_item_t oslot_q [2];
	logic owptr_q;
	logic orptr_q;
	logic [1:0] ocnt_q;

	logic retire;
	logic wr_row;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [7:0] b_raw;
	logic [7:0] pred;
	logic [7:0] val;
	logic [8:0] sum_ab;
	logic signed [9:0] da;
	logic signed [9:0] db;
	logic signed [9:0] dc;
	logic [9:0] pa;
	logic [9:0] pb;
	logic [9:0] pc;
	out_item_t res;

	assign retire = s1_valid_s1 && (ocnt_q != 2'd2);
	assign q_pop = !q_empty && (!s1_valid_s1 || retire);
	assign wr_row = retire && !s1_cmd_s1.pass;

	pru_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_row (
		.clk(clk),
		.we(wr_row),
		.waddr(s1_cmd_s1.col),
		.wdata(val),
		.re(q_pop),
		.raddr(q_cmd.col),
		.rdata(rd_data)
	);

	always_comb begin
		b_raw = fwd_s1 ? wval_q : rd_data;
		a = (s1_cmd_s1.col == '0) ? 8'd0 : left_q;
		b = s1_cmd_s1.first_row ? 8'd0 : b_raw;
		c = (s1_cmd_s1.col == '0 || s1_cmd_s1.first_row) ? 8'd0 : upleft_q;
		sum_ab = {1'b0, a} + {1'b0, b};
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({1'b0, sum_ab}) - $signed({2'b00, c}) - $signed({2'b00, c});
		pa = da[9] ? 10'(-da) : 10'(da);
		pb = db[9] ? 10'(-db) : 10'(db);
		pc = dc[9] ? 10'(-dc) : 10'(dc);
		unique case (s1_cmd_s1.filt)
			FILT_SUB: pred = a;
			FILT_UP: pred = b;
			FILT_AVG: pred = sum_ab[8:1];
			FILT_PAETH: begin
				if (pa <= pb && pa <= pc) begin
					pred = a;
				end else if (pb <= pc) begin
					pred = b;
				end else begin
					pred = c;
				end
			end
			default: pred = 8'd0;
		endcase
		val = s1_cmd_s1.data_byte + pred;
		res.out_byte = s1_cmd_s1.pass ? s1_cmd_s1.data_byte : val;
		res.row_end = s1_cmd_s1.ends;
		res.bad_filter = s1_cmd_s1.bad;
		res.last_out = s1_cmd_s1.last;
	end

	// decode stage
	always_ff @(posedge clk) begin
		if (q_pop) begin
			s1_cmd_s1 <= q_cmd;
		end
		if (wr_row) begin
			left_q <= val;
			upleft_q <= b;
			wval_q <= val;
		end
		if (retire) begin
			oslot_q[owptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (q_pop) begin
				s1_valid_s1 <= 1'b1;
				fwd_s1 <= wr_row && (q_cmd.col == s1_cmd_s1.col);
			end else if (retire) begin
				s1_valid_s1 <= 1'b0;
			end
			if (retire) begin
				owptr_q <= !owptr_q;
			end
			if (pop && !empty) begin
				orptr_q <= !orptr_q;
			end
			if (retire && !(pop && !empty)) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (!retire && pop && !empty) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign result = oslot_q[orptr_q];

endmodule
`default_nettype wire

// File: src/png_row_unfilter.sv
`default_nettype none
// PNG row unfilter at one byte per pixel, sustaining one input beat per clock while the
// command queue is not full: a front part tracks row position and the filter byte, a
// two-entry queue decouples it from the back part, which reads the line store (4096 x 8,
// one write and one registered read port), applies none/Sub/Up/Average/Paeth (or passes
// bytes through when PNG mode is off) and places results in a two-entry output queue.
// Filter bytes give no result. The line store needs no clearing; registers are to be
// written only while the block is idle, by the user: the block itself does not enforce this.
module png_row_unfilter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire pru_pkg::in_item_t item,
	output logic empty,
	input wire logic pop,
	output pru_pkg::out_item_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pru_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	assign full = q_full;

	pru_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_wr_cmd)
	);

	pru_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.wr_cmd(q_wr_cmd),
		.full(q_full),
		.rd(q_pop),
		.rd_cmd(q_rd_cmd),
		.empty(q_empty)
	);

	pru_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(q_rd_cmd),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
`default_nettype wire
